[hw/rtl/stts_pkg.sv]
// shared constants and types for the sorted table ternary search block
package stts_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = IDX_W + 1;
	localparam int WORD_W      = 32;

	// floor(x/3) = (x * RECIP_3) >> RECIP_SH, exact for x below TABLE_DEPTH
	localparam int RECIP_SH    = IDX_W + 1;
	localparam int RECIP_3     = ((1 << RECIP_SH) + 2) / 3;
	localparam int PROD_W      = IDX_W + RECIP_SH;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam int  PADDR_W         = 3;
	localparam logic REG_ENTRY_COUNT = 1'b0;

	// probe positions for one round over [left, hi-1]
	typedef struct packed {
		logic             empty;
		logic [IDX_W-1:0] mid1;
		logic [IDX_W-1:0] mid2;
	} probe_t;

endpackage

[hw/rtl/stts_probe.sv]
// computes the two ternary probe positions of the current search range
module stts_probe
	import stts_pkg::*;
(
	input  logic [CNT_W-1:0] left,
	input  logic [CNT_W-1:0] hi,
	output probe_t           probe
);

	logic [CNT_W-1:0]  span;
	logic [IDX_W-1:0]  diff;
	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0]  third;
	logic [CNT_W-1:0]  m1_wide;
	logic [CNT_W-1:0]  m2_wide;

	always_comb begin
		// right - left, with right = hi - 1
		span    = hi - left - CNT_W'(1);
		diff    = span[IDX_W-1:0];
		prod    = PROD_W'(diff) * PROD_W'(RECIP_3);
		third   = IDX_W'(prod >> RECIP_SH);
		m1_wide = left + CNT_W'(third);
		m2_wide = span + left - CNT_W'(third);
		probe.empty = (left >= hi);
		probe.mid1  = m1_wide[IDX_W-1:0];
		probe.mid2  = m2_wide[IDX_W-1:0];
	end

endmodule

[hw/rtl/sorted_table_ternary_search.sv]
// sorted table ternary search: table memory, search sequencer and ports
//
// Holds a table of TABLE_DEPTH signed 32-bit words in a dual-read memory.
// Input stream (s_*): s_tuser is the opcode; a write request stores
// word_value at entry_index and gives no result; a search request looks for
// word_value among entries 0 .. entry_count-1 by ternary search and gives
// one result on the output stream (m_*): m_tuser = found, m_tdata = index
// (zero when not found). The APB port sets entry_count at byte address 0
// from pwdata bits [10:0]; values above the table depth act as the full depth.
// A search runs ternary rounds of two states (ST_READ issues both probe
// reads, ST_COMP compares the registered read data) until a match or until
// ST_READ sees the range empty, then hands off in ST_HOLD; over 1024 entries
// that is at most 7 rounds, and the next request is taken once the sequencer
// is back in idle. Requests are taken only while no search is running; a
// write may follow a finished result while that result still waits in the
// output register. If the receiver stalls, the next search runs but holds
// its result until the output register frees. Reset empties the output
// register, returns the sequencer to idle and clears entry_count; table
// contents are undefined until written.
module sorted_table_ternary_search
	import stts_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [47:0]        s_tdata,   // entry_index[9:0], word_value[41:10], zero pad
	input  logic               s_tuser,   // opcode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,   // match_index[9:0], zero pad
	output logic               m_tuser,   // found
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_COMP = 4'b0100,
		ST_HOLD = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   left_q;
	logic [CNT_W-1:0]   hi_q;
	logic [WORD_W-1:0]  key_q;
	logic [IDX_W-1:0]   m1_q;
	logic [IDX_W-1:0]   m2_q;
	logic [WORD_W-1:0]  rd1_q;
	logic [WORD_W-1:0]  rd2_q;
	logic               found_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [WORD_W-1:0]  table_q [TABLE_DEPTH];

	probe_t             probe;
	logic               in_req;
	logic               wr_en;
	logic [IDX_W-1:0]   in_index;
	logic [WORD_W-1:0]  in_word;
	logic               out_free;
	logic               hold_load;
	logic [CNT_W-1:0]   count_sat;
	logic               cfg_wr;

	assign in_index  = s_tdata[IDX_W-1:0];
	assign in_word   = s_tdata[IDX_W+WORD_W-1:IDX_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_req    = s_tvalid && s_tready;
	assign wr_en     = in_req && (s_tuser == OP_WRITE);
	assign out_free  = !out_valid_q || m_tready;
	assign hold_load = (state_q == ST_HOLD) && out_free;
	assign count_sat = (count_q > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_q;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {{(16-IDX_W){1'b0}}, out_idx_q};

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
	assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {{(32-CNT_W){1'b0}}, count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wr) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	stts_probe u_probe (
		.left  (left_q),
		.hi    (hi_q),
		.probe (probe)
	);

	// table memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[in_index] <= in_word;
		end
		rd1_q <= table_q[probe.mid1];
		rd2_q <= table_q[probe.mid2];
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_req) begin
					key_q  <= in_word;
					left_q <= '0;
					hi_q   <= count_sat;
				end
			end
			ST_READ: begin
				m1_q <= probe.mid1;
				m2_q <= probe.mid2;
				if (probe.empty) begin
					found_q <= 1'b0;
					idx_q   <= '0;
				end
			end
			ST_COMP: begin
				if ($signed(rd1_q) == $signed(key_q)) begin
					found_q <= 1'b1;
					idx_q   <= m1_q;
				end else if ($signed(rd2_q) == $signed(key_q)) begin
					found_q <= 1'b1;
					idx_q   <= m2_q;
				end else if ($signed(rd1_q) > $signed(key_q)) begin
					hi_q <= CNT_W'(m1_q);
				end else if ($signed(rd2_q) < $signed(key_q)) begin
					left_q <= CNT_W'(m2_q) + CNT_W'(1);
				end else begin
					left_q <= CNT_W'(m1_q) + CNT_W'(1);
					hi_q   <= CNT_W'(m2_q);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (hold_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_req && (s_tuser == OP_SEARCH)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= probe.empty ? ST_HOLD : ST_COMP;
				end
				ST_COMP: begin
					if (($signed(rd1_q) == $signed(key_q)) ||
					    ($signed(rd2_q) == $signed(key_q))) begin
						state_q <= ST_HOLD;
					end else begin
						state_q <= ST_READ;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hold_load) begin
			out_found_q <= found_q;
			out_idx_q   <= idx_q;
		end
	end

`ifndef SYNTH
	// probes of a live round lie inside the range, first not after second
	a_probe_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && !probe.empty) |->
		(probe.mid1 <= probe.mid2) && (CNT_W'(probe.mid1) >= left_q) &&
		(CNT_W'(probe.mid2) < hi_q))
		else $error("probe positions outside search range");

	// the range only shrinks between rounds
	a_range_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP) |=>
		(state_q != ST_READ) || (hi_q - left_q < $past(hi_q) - $past(left_q)) ||
		(left_q >= hi_q))
		else $error("search range did not shrink");

	// a not-found result carries index zero
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 16'd0))
		else $error("not-found result with nonzero index");

	// a result is loaded only from the hold state
	a_load_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ($past(state_q) == ST_HOLD))
		else $error("result appeared outside hand-off");

	// no request is taken while a search runs
	a_no_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_COMP || state_q == ST_HOLD) |-> !s_tready)
		else $error("request taken during search");
`endif

endmodule

[sim/tb_sorted_table_ternary_search.sv]
// testbench for the sorted table ternary search block: table loads, searches and count settings
`timescale 1ns / 1ps

import stts_pkg::*;

class ternary_search_scoreboard;
	logic signed [WORD_W-1:0] words [TABLE_DEPTH];
	logic [CNT_W-1:0] entry_count;
	bit exp_found [$];
	logic [IDX_W-1:0] exp_index [$];
	int errors;

	function new();
		entry_count = '0;
		errors = 0;
	endfunction

	function void set_count(logic [31:0] value);
		entry_count = value[CNT_W-1:0];
	endfunction

	function int pending();
		return exp_found.size();
	endfunction

	// a write updates the table, a search predicts one result
	function void note_request(logic op, logic [IDX_W-1:0] pos,
		logic signed [WORD_W-1:0] key);
		int lo, hi, third, m1, m2, span;
		bit hit;
		logic [IDX_W-1:0] where;
		if (op == OP_WRITE) begin
			words[pos] = key;
			return;
		end
		span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
		lo = 0;
		hi = span - 1;
		hit = 1'b0;
		where = '0;
		// mid1 is checked before mid2, and the narrowing order is fixed
		while (!hit && lo <= hi) begin
			third = (hi - lo) / 3;
			m1 = lo + third;
			m2 = hi - third;
			if (words[m1] == key) begin
				hit = 1'b1;
				where = m1[IDX_W-1:0];
			end else if (words[m2] == key) begin
				hit = 1'b1;
				where = m2[IDX_W-1:0];
			end else if (words[m1] > key) begin
				hi = m1 - 1;
			end else if (words[m2] < key) begin
				lo = m2 + 1;
			end else begin
				lo = m1 + 1;
				hi = m2 - 1;
			end
		end
		exp_found.push_back(hit);
		exp_index.push_back(where);
	endfunction

	function void check_result(logic found, logic [IDX_W-1:0] index);
		bit want_found;
		logic [IDX_W-1:0] want_index;
		if (exp_found.size() == 0) begin
			$display("%0t unexpected result: found %0d index %0d", $time, found, index);
			errors++;
			return;
		end
		want_found = exp_found.pop_front();
		want_index = exp_index.pop_front();
		if (found !== want_found) begin
			$display("%0t found mismatch: expected %0d actual %0d", $time, want_found, found);
			errors++;
		end
		if (index !== want_index) begin
			$display("%0t match_index mismatch: expected %0d actual %0d", $time,
				want_index, index);
			errors++;
		end
	endfunction
endclass

module tb_sorted_table_ternary_search;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 6;
	localparam int DRAIN_CYCLES   = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEM_TARGET    = 1650;
	localparam int DATA_PAD       = 48 - IDX_W - WORD_W;
	localparam int COUNT_MAX      = (1 << CNT_W) - 1;

	localparam logic [PADDR_W-1:0] COUNT_ADDR    = PADDR_W'(4 * REG_ENTRY_COUNT);
	localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);

	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam longint WORD_LO = -64'sd2147483648;
	localparam longint WORD_HI = 64'sd2147483647;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [47:0]        s_tdata;   // entry_index[9:0], word_value[41:10], zero pad
	logic               s_tuser;   // opcode
	logic               m_tvalid;
	logic               m_tready;
	logic [15:0]        m_tdata;   // match_index[9:0], zero pad
	logic               m_tuser;   // found
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	ternary_search_scoreboard sb;
	int items_sent;
	int filled;
	int rx_hold;
	int stall_cycles;
	bit tx_idle_on;
	bit rx_idle_on;

	sorted_table_ternary_search dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata[IDX_W-1:0]);
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
			m_tready <= 1'b0;
			rx_hold <= stall_len() - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
			(psel && penable && pwrite && pready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_request(logic op, logic [IDX_W-1:0] pos,
		logic signed [WORD_W-1:0] value);
		int gap;
		gap = (tx_idle_on && $urandom_range(0, 99) < 35) ? stall_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{DATA_PAD{1'b0}}, value, pos};
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, pos, value);
		items_sent++;
	endtask

	// stop sending and let every search finish before touching the register
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == COUNT_ADDR)
			sb.set_count(data);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// entries 0..n-1: ascending, ascending with repeats, or random order
	task automatic load_table(int n);
		int mode, i;
		longint acc, step_max;
		logic signed [WORD_W-1:0] value;
		mode = $urandom_range(0, 9);
		case ($urandom_range(0, 2))
			0: step_max = 4;
			1: step_max = 2000;
			default: step_max = 64'd4294967295 / (n + 1);
		endcase
		acc = WORD_LO;
		if ($urandom_range(0, 3) != 0)
			acc = acc + ($urandom % step_max);
		for (i = 0; i < n; i++) begin
			if (mode < 2) begin
				value = $urandom;
			end else begin
				if (i > 0 && !(mode < 4 && $urandom_range(0, 2) == 0))
					acc = acc + 1 + ($urandom % step_max);
				if (acc > WORD_HI)
					acc = WORD_HI;
				value = acc[WORD_W-1:0];
			end
			send_request(OP_WRITE, i[IDX_W-1:0], value);
		end
		if (n > filled)
			filled = n;
	endtask

	task automatic search_burst(int nsearch);
		int k, span, r, pos;
		logic signed [WORD_W-1:0] key;
		span = (sb.entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sb.entry_count);
		for (k = 0; k < nsearch; k++) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				// stray write in the middle of searches
				pos = $urandom_range(0, TABLE_DEPTH - 1);
				key = (pos < span) ? sb.words[pos] + 1 : $urandom;
				send_request(OP_WRITE, pos[IDX_W-1:0], key);
			end else begin
				if (span > 0 && r < 60)
					key = sb.words[$urandom_range(0, span - 1)];
				else if (span > 0 && r < 78)
					key = sb.words[$urandom_range(0, span - 1)] +
						($urandom_range(0, 1) ? 1 : -1);
				else if (r < 88)
					key = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
				else
					key = $urandom;
				send_request(OP_SEARCH, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), key);
			end
		end
	endtask

	initial begin
		logic signed [WORD_W-1:0] corner [8];
		logic [31:0] cfg;
		int phase, n, cnt, r, i;

		sb = new();
		clk = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_WRITE;
		m_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		items_sent = 0;
		filled = 0;
		rx_hold = 0;
		stall_cycles = 0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// count zero after reset: not found without reading the table
		send_request(OP_SEARCH, '0, '0);

		corner[0] = WORD_MIN;
		corner[1] = -1000;
		corner[2] = -1;
		corner[3] = 0;
		corner[4] = 1;
		corner[5] = 77;
		corner[6] = 5000;
		corner[7] = WORD_MAX;
		for (i = 0; i < 8; i++)
			send_request(OP_WRITE, i[IDX_W-1:0], corner[i]);
		send_request(OP_WRITE, IDX_W'(TABLE_DEPTH - 1), 32'sh5a5a_a5a5);
		filled = 8;

		cfg_write(COUNT_ADDR, 8);
		send_request(OP_SEARCH, '0, WORD_MIN);
		send_request(OP_SEARCH, '1, WORD_MAX);
		send_request(OP_SEARCH, '0, 0);
		send_request(OP_SEARCH, '0, 77);
		send_request(OP_SEARCH, '0, -1000);
		send_request(OP_SEARCH, '0, 2);
		send_request(OP_SEARCH, '0, -2);

		// single entry, then a write to an unmapped register must not move the count
		cfg_write(COUNT_ADDR, 1);
		send_request(OP_SEARCH, '0, WORD_MIN);
		send_request(OP_SEARCH, '0, 5);
		cfg_write(UNMAPPED_ADDR, 8);
		send_request(OP_SEARCH, '0, WORD_MAX);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				load_table(TABLE_DEPTH);
				cfg_write(COUNT_ADDR, TABLE_DEPTH);
				search_burst(120);
			end else if (phase == 3) begin
				// above the depth, with junk in the upper data bits
				cfg = COUNT_MAX;
				cfg[31:CNT_W] = (32 - CNT_W)'($urandom);
				cfg_write(COUNT_ADDR, cfg);
				search_burst(60);
			end else begin
				r = $urandom_range(0, 99);
				n = (r < 70) ? $urandom_range(1, 16) :
					(r < 90) ? $urandom_range(17, 100) : 0;
				if (n > 0)
					load_table(n);
				cnt = n;
				if ($urandom_range(0, 9) == 0)
					cnt = $urandom_range(0, filled);
				if (filled == TABLE_DEPTH && $urandom_range(0, 9) == 0)
					cnt = $urandom_range(TABLE_DEPTH, COUNT_MAX);
				cfg = cnt;
				if ($urandom_range(0, 7) == 0)
					cfg[31:CNT_W] = (32 - CNT_W)'($urandom);
				cfg_write(COUNT_ADDR, cfg);
				search_burst($urandom_range(10, 30));
			end
			phase++;
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/stts_pkg.sv
hw/rtl/stts_probe.sv
hw/rtl/sorted_table_ternary_search.sv
sim/tb_sorted_table_ternary_search.sv
